// ===== sv/radix2_fft_real_input_macros.svh =====
// Assertion macros for the real-input FFT block.
// Each macro uses the clk and rst signals of the module that includes it.
`ifndef RADIX2_FFT_REAL_INPUT_MACROS_SVH
`define RADIX2_FFT_REAL_INPUT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fftr_pkg.sv =====
// Shared types, constants and twiddle generation for the real-input FFT.
// Used by fftr_ctrl, fftr_datapath and radix2_fft_real_input; no dependencies.
package fftr_pkg;

  localparam int WORK_BITS      = 20;
  localparam int TW_MAX_BITS    = 24;
  localparam int BIN_INDEX_BITS = 4;
  localparam int OUT_TDATA_BITS = ((2 * WORK_BITS + BIN_INDEX_BITS + 7) / 8) * 8;
  localparam int CFG_BITS       = 3;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 3'd4;

  // Cycles from the last butterfly issue of a stage until its results are in memory.
  localparam int DRAIN_CYCLES = 5;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned COS_DIV [1:10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};
  localparam longint unsigned SIN_DIV [1:10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  typedef struct packed {
    logic load_we;
    logic bf_issue;
    logic out_issue;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic out_can_issue;
    logic out_busy;
  } status_t;

  // Rounds a Q1.30 value to the twiddle format, capping the magnitude.
  function automatic logic [TW_MAX_BITS-1:0] to_twiddle(longint v, int unsigned tw_bits);
    logic neg;
    longint unsigned a;
    longint unsigned r;
    longint unsigned cap;
    neg = (v < 0);
    a   = neg ? longint'(-v) : longint'(v);
    cap = (64'd1 << (tw_bits - 1)) - 64'd1;
    r   = (a + (64'd1 << (30 - tw_bits))) >> (31 - tw_bits);
    if (r > cap) begin
      r = cap;
    end
    return neg ? TW_MAX_BITS'(-longint'(r)) : TW_MAX_BITS'(r);
  endfunction

  // Twiddle for angle 2*pi*m/2^log2_max, returned as {sine, cosine}.
  function automatic logic [2*TW_MAX_BITS-1:0] twiddle_entry(int unsigned m,
                                                             int unsigned log2_max,
                                                             int unsigned tw_bits);
    longint unsigned big;
    longint unsigned ang;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned tc;
    longint unsigned ts;
    longint sc;
    longint ss;
    logic second;
    logic [TW_MAX_BITS-1:0] wc;
    logic [TW_MAX_BITS-1:0] ws;
    big    = 64'd1 << log2_max;
    second = (64'(m) * 64'd4 >= big);
    ang    = second ? 64'(m) - (big >> 2) : 64'(m);
    x      = (64'd2 * PI_Q30 * ang) >> log2_max;
    x2     = (x * x) >> 30;
    tc     = 64'd1 << 30;
    ts     = x;
    sc     = longint'(tc);
    ss     = longint'(ts);
    for (int n = 1; n <= 10; n++) begin
      tc = ((tc * x2) >> 30) / COS_DIV[n];
      ts = ((ts * x2) >> 30) / SIN_DIV[n];
      if (n % 2 == 1) begin
        sc = sc - longint'(tc);
        ss = ss - longint'(ts);
      end else begin
        sc = sc + longint'(tc);
        ss = ss + longint'(ts);
      end
    end
    if (second) begin
      wc = to_twiddle(-ss, tw_bits);
      ws = to_twiddle(sc, tw_bits);
    end else begin
      wc = to_twiddle(sc, tw_bits);
      ws = to_twiddle(ss, tw_bits);
    end
    return {ws, wc};
  endfunction

endpackage

// ===== sv/fftr_ctrl.sv =====
// Controller of the real-input FFT: load, butterfly, drain and output sequencing.
// Depends on fftr_pkg; drives the command and address inputs of fftr_datapath.
module fftr_ctrl #(
  parameter int MAX_POINTS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [fftr_pkg::CFG_BITS-1:0]         cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  output fftr_pkg::cmd_t                        cmd,
  input  fftr_pkg::status_t                     status,
  output logic [$clog2(MAX_POINTS)-1:0]         rd_addr_a,
  output logic [$clog2(MAX_POINTS)-1:0]         rd_addr_b,
  output logic [$clog2(MAX_POINTS)-1:0]         load_addr,
  output logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] tw_idx
);

  localparam int LOG2_MAX = $clog2(MAX_POINTS);
  localparam int ADDR_W   = LOG2_MAX;
  localparam int LG_W     = $clog2(LOG2_MAX + 1);
  localparam int TW_IDX_W = (LOG2_MAX > 1) ? LOG2_MAX - 1 : 1;
  localparam int DRAIN_W  = fftr_pkg::DRAIN_W;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_WAIT  = 5'b00010,
    ST_BFLY  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t                        state, state_next;
  logic [fftr_pkg::CFG_BITS-1:0] log2_points, log2_points_next;
  logic [ADDR_W-1:0]             load_count, load_count_next;
  logic [ADDR_W-1:0]             bf_cnt, bf_cnt_next;
  logic [ADDR_W-1:0]             out_cnt, out_cnt_next;
  logic [LG_W-1:0]               stage, stage_next;
  logic [DRAIN_W-1:0]            drain_cnt, drain_cnt_next;
  logic                          phase, phase_next;

  logic [LG_W-1:0]   lg;
  logic [ADDR_W-1:0] last_pt;
  logic [ADDR_W-1:0] last_bf;
  logic [ADDR_W-1:0] half;
  logic [ADDR_W-1:0] low_mask;
  logic [ADDR_W-1:0] addr_lo;

  function automatic logic [ADDR_W-1:0] bit_rev(logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = v[ADDR_W-1-i];
    end
    return r;
  endfunction

  always_comb begin
    lg       = (32'(log2_points) > LOG2_MAX) ? LG_W'(LOG2_MAX) : LG_W'(log2_points);
    last_pt  = ADDR_W'((32'd1 << lg) - 32'd1);
    last_bf  = (lg != '0) ? ADDR_W'((32'd1 << (32'(lg) - 32'd1)) - 32'd1) : '0;
    half     = ADDR_W'(32'd1 << stage);
    low_mask = half - ADDR_W'(1);
    addr_lo  = ADDR_W'((32'(bf_cnt) >> stage) << (32'(stage) + 32'd1)) | (bf_cnt & low_mask);
    tw_idx   = TW_IDX_W'(32'(bf_cnt & low_mask) << (LOG2_MAX - 1 - 32'(stage)));
    load_addr = bit_rev(load_count) >> (LOG2_MAX - 32'(lg));
  end

  assign s_tready      = (state == ST_LOAD);
  assign cmd.load_we   = s_tvalid && s_tready;
  assign cmd.bf_issue  = (state == ST_BFLY) && !phase;
  assign cmd.out_issue = (state == ST_OUT) && status.out_can_issue;
  assign cmd.out_last  = (out_cnt == last_pt);
  assign rd_addr_a     = (state == ST_OUT) ? out_cnt : addr_lo;
  assign rd_addr_b     = addr_lo | half;

  always_comb begin
    state_next       = state;
    log2_points_next = log2_points;
    load_count_next  = load_count;
    bf_cnt_next      = bf_cnt;
    out_cnt_next     = out_cnt;
    stage_next       = stage;
    drain_cnt_next   = drain_cnt;
    phase_next       = phase;
    unique case (state)
      ST_LOAD: begin
        if (cmd.load_we) begin
          if (load_count == last_pt) begin
            load_count_next = '0;
            out_cnt_next    = '0;
            state_next      = (lg == '0) ? ST_OUT : ST_WAIT;
          end else begin
            load_count_next = load_count + ADDR_W'(1);
          end
        end
      end
      ST_WAIT: begin
        if (!status.out_busy) begin
          stage_next  = '0;
          bf_cnt_next = '0;
          phase_next  = 1'b0;
          state_next  = ST_BFLY;
        end
      end
      ST_BFLY: begin
        phase_next = !phase;
        if (cmd.bf_issue) begin
          if (bf_cnt == last_bf) begin
            bf_cnt_next    = '0;
            drain_cnt_next = '0;
            state_next     = ST_DRAIN;
          end else begin
            bf_cnt_next = bf_cnt + ADDR_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        drain_cnt_next = drain_cnt + DRAIN_W'(1);
        if (drain_cnt == DRAIN_W'(fftr_pkg::DRAIN_CYCLES - 1)) begin
          phase_next = 1'b0;
          if (stage == LG_W'(32'(lg) - 32'd1)) begin
            stage_next   = '0;
            out_cnt_next = '0;
            state_next   = ST_OUT;
          end else begin
            stage_next = stage + LG_W'(1);
            state_next = ST_BFLY;
          end
        end
      end
      ST_OUT: begin
        if (cmd.out_issue) begin
          if (out_cnt == last_pt) begin
            out_cnt_next = '0;
            state_next   = ST_LOAD;
          end else begin
            out_cnt_next = out_cnt + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
    if (cfg_we) begin
      log2_points_next = cfg_wdata;
      load_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      log2_points <= fftr_pkg::CFG_RESET;
      load_count  <= '0;
      bf_cnt      <= '0;
      out_cnt     <= '0;
      stage       <= '0;
      drain_cnt   <= '0;
      phase       <= 1'b0;
    end else begin
      state       <= state_next;
      log2_points <= log2_points_next;
      load_count  <= load_count_next;
      bf_cnt      <= bf_cnt_next;
      out_cnt     <= out_cnt_next;
      stage       <= stage_next;
      drain_cnt   <= drain_cnt_next;
      phase       <= phase_next;
    end
  end

endmodule

// ===== sv/fftr_datapath.sv =====
// Datapath of the real-input FFT: work memory, twiddle table, butterfly pipeline
// and output register stages. Depends on fftr_pkg; commanded by fftr_ctrl.
module fftr_datapath #(
  parameter int MAX_POINTS   = 16,
  parameter int SAMPLE_BITS  = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fftr_pkg::cmd_t                        cmd,
  output fftr_pkg::status_t                     status,
  input  logic [$clog2(MAX_POINTS)-1:0]         rd_addr_a,
  input  logic [$clog2(MAX_POINTS)-1:0]         rd_addr_b,
  input  logic [$clog2(MAX_POINTS)-1:0]         load_addr,
  input  logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] tw_idx,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fftr_pkg::WORK_BITS-1:0] out_real,
  output logic signed [fftr_pkg::WORK_BITS-1:0] out_imag,
  output logic [fftr_pkg::BIN_INDEX_BITS-1:0]   out_index,
  output logic                                  out_last
);

  localparam int LOG2_MAX = $clog2(MAX_POINTS);
  localparam int ADDR_W   = LOG2_MAX;
  localparam int TW_IDX_W = (LOG2_MAX > 1) ? LOG2_MAX - 1 : 1;
  localparam int TW_DEPTH = 1 << TW_IDX_W;
  localparam int TWM      = fftr_pkg::TW_MAX_BITS;
  localparam int TW       = TWIDDLE_BITS;
  localparam int WB       = fftr_pkg::WORK_BITS;
  localparam int PROD_W   = WB + TW;
  localparam int SUM_W    = PROD_W + 1;
  localparam int P_W      = WB + 2;
  localparam int BF_W     = WB + 3;
  localparam int SX_W     = (SAMPLE_BITS > WB) ? SAMPLE_BITS : WB;

  localparam logic signed [SUM_W-1:0] RND   = SUM_W'(2 ** (TW - 2));
  localparam logic signed [BF_W-1:0]  BF_HI = BF_W'(2 ** (WB - 1) - 1);
  localparam logic signed [BF_W-1:0]  BF_LO = BF_W'(-(2 ** (WB - 1)));
  localparam logic signed [SX_W-1:0]  SX_HI = SX_W'(2 ** (WB - 1) - 1);
  localparam logic signed [SX_W-1:0]  SX_LO = SX_W'(-(2 ** (WB - 1)));

  function automatic logic signed [WB-1:0] sat_bf(logic signed [BF_W-1:0] v);
    return (v > BF_HI) ? BF_HI[WB-1:0] : ((v < BF_LO) ? BF_LO[WB-1:0] : v[WB-1:0]);
  endfunction

  // Work memory, one entry per point as {imag, real}.
  logic [2*WB-1:0] mem [MAX_POINTS];
  logic [2*WB-1:0] rd_a;
  logic [2*WB-1:0] rd_b;
  logic            wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [2*WB-1:0] wr_data;

  // Twiddle table, one entry per angle as {sine, cosine}.
  logic [2*TW-1:0] tw_rom [TW_DEPTH];

  for (genvar m = 0; m < TW_DEPTH; m++) begin : g_tw
    logic [2*TWM-1:0] ent;
    assign ent       = fftr_pkg::twiddle_entry(m, LOG2_MAX, TW);
    assign tw_rom[m] = {ent[TWM +: TW], ent[TW-1:0]};
  end

  logic signed [SX_W-1:0] sx;
  logic signed [WB-1:0]   sample_sat;

  always_comb begin
    sx         = SX_W'(sample);
    sample_sat = (sx > SX_HI) ? SX_HI[WB-1:0] : ((sx < SX_LO) ? SX_LO[WB-1:0] : sx[WB-1:0]);
  end

  // Butterfly pipeline.
  logic                 bv1, bv2, bv3, bv4, bv5;
  logic [ADDR_W-1:0]    ba1, bb1, ba2, bb2, ba3, bb3, ba4, bb4;
  logic signed [TW-1:0] tw_c1, tw_s1;
  logic signed [WB-1:0] br1, bi1, ar1, ai1;
  logic signed [PROD_W-1:0] prod_rc, prod_is, prod_ic, prod_rs;
  logic signed [WB-1:0] ar2, ai2, ar3, ai3;
  logic signed [SUM_W-1:0] sum_r, sum_i, rnd_r, rnd_i, shf_r, shf_i;
  logic signed [P_W-1:0] p_r, p_i;
  logic signed [WB-1:0] ya_r, ya_i, yb_r, yb_i;

  assign ar1 = rd_a[WB-1:0];
  assign ai1 = rd_a[2*WB-1:WB];
  assign br1 = rd_b[WB-1:0];
  assign bi1 = rd_b[2*WB-1:WB];

  always_comb begin
    sum_r = SUM_W'(prod_rc) + SUM_W'(prod_is);
    sum_i = SUM_W'(prod_ic) - SUM_W'(prod_rs);
    rnd_r = sum_r + RND;
    rnd_i = sum_i + RND;
    shf_r = rnd_r >>> (TW - 1);
    shf_i = rnd_i >>> (TW - 1);
  end

  always_comb begin
    wr_en   = cmd.load_we || bv4 || bv5;
    wr_addr = bb4;
    wr_data = {yb_i, yb_r};
    if (cmd.load_we) begin
      wr_addr = load_addr;
      wr_data = {WB'(0), sample_sat};
    end else if (bv4) begin
      wr_addr = ba4;
      wr_data = {ya_i, ya_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.bf_issue || cmd.out_issue) begin
      rd_a <= mem[rd_addr_a];
    end
    if (cmd.bf_issue) begin
      rd_b  <= mem[rd_addr_b];
      tw_c1 <= tw_rom[tw_idx][TW-1:0];
      tw_s1 <= tw_rom[tw_idx][2*TW-1:TW];
      ba1   <= rd_addr_a;
      bb1   <= rd_addr_b;
    end
  end

  always_ff @(posedge clk) begin
    prod_rc <= br1 * tw_c1;
    prod_is <= bi1 * tw_s1;
    prod_ic <= bi1 * tw_c1;
    prod_rs <= br1 * tw_s1;
    ar2     <= ar1;
    ai2     <= ai1;
    ba2     <= ba1;
    bb2     <= bb1;
    p_r     <= P_W'(shf_r);
    p_i     <= P_W'(shf_i);
    ar3     <= ar2;
    ai3     <= ai2;
    ba3     <= ba2;
    bb3     <= bb2;
    if (bv3) begin
      ya_r <= sat_bf(BF_W'(ar3) + BF_W'(p_r));
      ya_i <= sat_bf(BF_W'(ai3) + BF_W'(p_i));
      yb_r <= sat_bf(BF_W'(ar3) - BF_W'(p_r));
      yb_i <= sat_bf(BF_W'(ai3) - BF_W'(p_i));
      ba4  <= ba3;
      bb4  <= bb3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv1 <= 1'b0;
      bv2 <= 1'b0;
      bv3 <= 1'b0;
      bv4 <= 1'b0;
      bv5 <= 1'b0;
    end else begin
      bv1 <= cmd.bf_issue;
      bv2 <= bv1;
      bv3 <= bv2;
      bv4 <= bv3;
      bv5 <= bv4;
    end
  end

  // Output stages: the memory read register, then the output register.
  logic              ov1;
  logic [ADDR_W-1:0] oidx1;
  logic              olast1;
  logic              adv2;

  assign adv2                 = ov1 && (!out_valid || out_ready);
  assign status.out_can_issue = !ov1 || adv2;
  assign status.out_busy      = ov1 || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov1       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_issue) begin
        ov1 <= 1'b1;
      end else if (adv2) begin
        ov1 <= 1'b0;
      end
      if (adv2) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_issue) begin
      oidx1  <= rd_addr_a;
      olast1 <= cmd.out_last;
    end
    if (adv2) begin
      out_real  <= rd_a[WB-1:0];
      out_imag  <= rd_a[2*WB-1:WB];
      out_index <= fftr_pkg::BIN_INDEX_BITS'(oidx1);
      out_last  <= olast1;
    end
  end

endmodule

// ===== sv/radix2_fft_real_input.sv =====
// Top level of the radix-2 decimation-in-time FFT on real samples; uses fftr_ctrl,
// fftr_datapath, fftr_pkg and radix2_fft_real_input_macros.svh.
// N points are loaded, then, once the previous frame's bins have drained, log2(N)
// butterfly stages run (butterflies spaced so their two result writes share the one write
// port, plus a pipeline drain per stage), then the N bins are output; N=1 skips the wait
// and the butterflies. Reset clears control state, not memory; log2_points=4.
module radix2_fft_real_input #(
  parameter int MAX_POINTS   = 16,
  parameter int SAMPLE_BITS  = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [fftr_pkg::CFG_BITS-1:0]         cfg_wdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [fftr_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,  // bin_real, bin_imag, bin_index
  output logic                                  m_axis_tlast   // last_bin
);

  `include "radix2_fft_real_input_macros.svh"

  localparam int LOG2_MAX = $clog2(MAX_POINTS);
  localparam int TW_IDX_W = (LOG2_MAX > 1) ? LOG2_MAX - 1 : 1;
  localparam int WB       = fftr_pkg::WORK_BITS;

  fftr_pkg::cmd_t    cmd;
  fftr_pkg::status_t status;
  logic [LOG2_MAX-1:0] rd_addr_a;
  logic [LOG2_MAX-1:0] rd_addr_b;
  logic [LOG2_MAX-1:0] load_addr;
  logic [TW_IDX_W-1:0] tw_idx;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [WB-1:0] bin_real;
  logic signed [WB-1:0] bin_imag;
  logic [fftr_pkg::BIN_INDEX_BITS-1:0] bin_index;

  assign sample       = s_axis_tdata[SAMPLE_BITS-1:0];
  assign m_axis_tdata = fftr_pkg::OUT_TDATA_BITS'({bin_index, bin_imag, bin_real});

  fftr_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .cmd       (cmd),
    .status    (status),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .load_addr (load_addr),
    .tw_idx    (tw_idx)
  );

  fftr_datapath #(
    .MAX_POINTS   (MAX_POINTS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .load_addr (load_addr),
    .tw_idx    (tw_idx),
    .sample    (sample),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_real  (bin_real),
    .out_imag  (bin_imag),
    .out_index (bin_index),
    .out_last  (m_axis_tlast)
  );

  `FFTR_ASSERT_NOW(a_bfly_after_output, cmd.bf_issue, !status.out_busy, "butterfly while bins pending")
  `FFTR_ASSERT_NEXT(a_bfly_spacing, cmd.bf_issue, !cmd.bf_issue, "butterflies issued back to back")
  `FFTR_ASSERT_NOW(a_load_alone, cmd.load_we, !cmd.bf_issue && !cmd.out_issue, "load during compute")

endmodule
